// ===== hw/rtl/bpsad_pkg.sv =====
// Shared widths, limits and stage tag type for the border-padded 32-wide SAD block.
package bpsad_pkg;

  localparam int ROW_PIXELS = 32;
  localparam int PIX_W      = 8;
  localparam int IDX_W      = $clog2(ROW_PIXELS);
  localparam int OVH_W      = 6;
  localparam int ROW_SAD_W  = PIX_W + IDX_W;
  localparam int SUM_W      = 20;
  localparam int OUT_W      = 19;
  localparam int MAX_ROWS   = 64;
  localparam int PIX_MAX    = (1 << PIX_W) - 1;

  localparam logic [SUM_W-1:0] SAD_LIMIT = SUM_W'(MAX_ROWS * ROW_PIXELS * PIX_MAX);

  typedef logic [ROW_PIXELS-1:0][PIX_W-1:0] bpsad_row_t;

  typedef struct packed {
    logic vld;
    logic last;
  } bpsad_tag_t;

endpackage

// ===== hw/rtl/bpsad_row_sad.sv =====
// Row stage: clamped window selection, absolute differences, adder tree and row register.
module bpsad_row_sad (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bpsad_pkg::bpsad_row_t          cur,
  input  bpsad_pkg::bpsad_row_t          win,
  input  logic [bpsad_pkg::OVH_W-1:0]    left,
  input  logic [bpsad_pkg::OVH_W-1:0]    right,
  input  bpsad_pkg::bpsad_tag_t          tag_in,
  input  logic                           take,
  output logic                           ready,
  output bpsad_pkg::bpsad_tag_t          tag_r,
  output logic [bpsad_pkg::ROW_SAD_W-1:0] row_sad_r
);
  import bpsad_pkg::*;

  localparam int POS_W = OVH_W + 2;

  // Window byte used by a column: the fetch offset undone, then clamped to the window.
  function automatic logic [IDX_W-1:0] win_index(input logic [IDX_W-1:0] col,
                                                 input logic [OVH_W-1:0] l,
                                                 input logic [OVH_W-1:0] r);
    logic [POS_W-1:0] pos;
    logic [IDX_W-1:0] idx;
    pos = POS_W'(col) + POS_W'(r) - POS_W'(l);
    if (pos[POS_W-1]) begin
      idx = '0;
    end else if (pos[POS_W-2:IDX_W] != '0) begin
      idx = IDX_W'(ROW_PIXELS - 1);
    end else begin
      idx = pos[IDX_W-1:0];
    end
    return idx;
  endfunction

  logic [ROW_PIXELS-1:0][PIX_W-1:0]     diff;
  logic [15:0][PIX_W:0]                 lvl1;
  logic [7:0][PIX_W+1:0]                lvl2;
  logic [3:0][PIX_W+2:0]                lvl3;
  logic [1:0][PIX_W+3:0]                lvl4;
  logic [ROW_SAD_W-1:0]                 row_sad_nxt;
  bpsad_tag_t                           tag_nxt;

  always_comb begin
    logic [PIX_W-1:0] ref_pix;
    for (int x = 0; x < ROW_PIXELS; x++) begin
      ref_pix = win[win_index(IDX_W'(x), left, right)];
      diff[x] = (cur[x] > ref_pix) ? (cur[x] - ref_pix) : (ref_pix - cur[x]);
    end
  end

  always_comb begin
    for (int i = 0; i < 16; i++) lvl1[i] = {1'b0, diff[2*i]} + {1'b0, diff[2*i+1]};
    for (int i = 0; i < 8; i++)  lvl2[i] = {1'b0, lvl1[2*i]} + {1'b0, lvl1[2*i+1]};
    for (int i = 0; i < 4; i++)  lvl3[i] = {1'b0, lvl2[2*i]} + {1'b0, lvl2[2*i+1]};
    for (int i = 0; i < 2; i++)  lvl4[i] = {1'b0, lvl3[2*i]} + {1'b0, lvl3[2*i+1]};
    row_sad_nxt = {1'b0, lvl4[0]} + {1'b0, lvl4[1]};
  end

  assign ready   = !tag_r.vld || take;
  assign tag_nxt = ready ? tag_in : tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready) begin
      row_sad_r <= row_sad_nxt;
    end
  end

endmodule

// ===== hw/rtl/bpsad_accum.sv =====
// Accumulator stage: saturating block total and the result register.
module bpsad_accum (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bpsad_pkg::bpsad_tag_t           tag,
  input  logic [bpsad_pkg::ROW_SAD_W-1:0] row_sad,
  output logic                            take,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bpsad_pkg::OUT_W-1:0]     out_block_sad
);
  import bpsad_pkg::*;

  logic [SUM_W-1:0] acc_r, acc_nxt;
  logic [SUM_W-1:0] sum_raw, sum_sat;
  logic             out_vld_r, out_vld_nxt;
  logic [OUT_W-1:0] out_sad_r;
  logic             emit;

  assign sum_raw = acc_r + SUM_W'(row_sad);
  assign sum_sat = (sum_raw > SAD_LIMIT) ? SAD_LIMIT : sum_raw;

  // A last row needs the result register free; other rows only touch the total.
  assign take = tag.vld && (!tag.last || !out_vld_r || !out_stall);
  assign emit = take && tag.last;

  always_comb begin
    acc_nxt     = acc_r;
    out_vld_nxt = out_vld_r && out_stall;
    if (take) begin
      acc_nxt = tag.last ? '0 : sum_sat;
    end
    if (emit) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      acc_r     <= acc_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_sad_r <= sum_sat[OUT_W-1:0];
    end
  end

  assign out_valid     = out_vld_r;
  assign out_block_sad = out_sad_r;

`ifndef ASSERT_OFF
  a_acc_limit: assert property (@(posedge clk) disable iff (!rst_n)
    acc_r <= SAD_LIMIT)
    else $error("running total above saturation limit");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> acc_r == '0)
    else $error("total not cleared after a last row");

  a_out_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> SUM_W'(out_sad_r) <= SAD_LIMIT)
    else $error("emitted total above saturation limit");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> !(out_vld_r && out_stall))
    else $error("held result overwritten");
`endif

endmodule

// ===== hw/rtl/border_padded_sad_32wide.sv =====
// Top level of the border-padded sum of absolute differences for 32-pixel-wide blocks.
//
// Each request is one block row: 32 current pixels, a 32-byte reference window
// fetched at offset overhang_left minus overhang_right, the two overhangs and a
// last-row flag. Reference column x is taken from window byte
// clamp(x - overhang_left + overhang_right, 0, 31), so columns past a picture
// border repeat the border pixel. Row sums are added into a running total that
// saturates at 64 * 32 * 255 = 522240; on the last row the total including that
// row is delivered as out_block_sad and the total starts again from zero. Rows
// that are not last produce no result. The block takes one row every cycle while
// the output is not stalled: each row passes through an input register, a row
// register that holds its 32-pixel SAD, and the accumulator, whose single add
// and compare close the only loop. A result is registered when its last row
// leaves the row register. The result register and the two stage registers
// absorb a stalled output, and in_stall rises only once all of them are full
// and the output is stalled. There is no start-up pass after reset.
module border_padded_sad_32wide (
  input  logic                        clk,
  input  logic                        rst_n,

  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [63:0]                 in_cur_bytes_0_7,
  input  logic [63:0]                 in_cur_bytes_8_15,
  input  logic [63:0]                 in_cur_bytes_16_23,
  input  logic [63:0]                 in_cur_bytes_24_31,
  input  logic [63:0]                 in_win_bytes_0_7,
  input  logic [63:0]                 in_win_bytes_8_15,
  input  logic [63:0]                 in_win_bytes_16_23,
  input  logic [63:0]                 in_win_bytes_24_31,
  input  logic [bpsad_pkg::OVH_W-1:0] in_overhang_left,
  input  logic [bpsad_pkg::OVH_W-1:0] in_overhang_right,
  input  logic                        in_last_row,

  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bpsad_pkg::OUT_W-1:0] out_block_sad
);
  import bpsad_pkg::*;

  // Input register: one row as it arrived.
  bpsad_row_t         cur_r;
  bpsad_row_t         win_r;
  logic [OVH_W-1:0]   left_r;
  logic [OVH_W-1:0]   right_r;
  bpsad_tag_t         in_tag_r, in_tag_nxt;

  // Stage hand-over signals.
  logic                 row_ready;
  bpsad_tag_t           row_tag;
  logic [ROW_SAD_W-1:0] row_sad;
  logic                 acc_take;
  logic                 in_load;

  // The input register reloads whenever it is empty or its row moves on.
  assign in_load  = !in_tag_r.vld || row_ready;
  assign in_stall = !in_load;

  always_comb begin
    in_tag_nxt = in_tag_r;
    if (in_load) begin
      in_tag_nxt.vld  = in_valid;
      in_tag_nxt.last = in_last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_tag_r <= '0;
    end else begin
      in_tag_r <= in_tag_nxt;
    end
  end

  // Payload needs no reset; the valid bit guards it.
  always_ff @(posedge clk) begin
    if (in_load) begin
      cur_r   <= {in_cur_bytes_24_31, in_cur_bytes_16_23, in_cur_bytes_8_15, in_cur_bytes_0_7};
      win_r   <= {in_win_bytes_24_31, in_win_bytes_16_23, in_win_bytes_8_15, in_win_bytes_0_7};
      left_r  <= in_overhang_left;
      right_r <= in_overhang_right;
    end
  end

  bpsad_row_sad u_row (
    .clk       (clk),
    .rst_n     (rst_n),
    .cur       (cur_r),
    .win       (win_r),
    .left      (left_r),
    .right     (right_r),
    .tag_in    (in_tag_r),
    .take      (acc_take),
    .ready     (row_ready),
    .tag_r     (row_tag),
    .row_sad_r (row_sad)
  );

  bpsad_accum u_accum (
    .clk           (clk),
    .rst_n         (rst_n),
    .tag           (row_tag),
    .row_sad       (row_sad),
    .take          (acc_take),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_block_sad (out_block_sad)
  );

endmodule
